[hdl/rl_pkg.sv]
// ----------------------------------------------------------------------------
// rl_pkg
// Shared codes and types of the per-client rate limiter.
// ----------------------------------------------------------------------------
package rl_pkg;

	// command codes
	localparam logic [1:0] CMD_CHECK   = 2'd0;
	localparam logic [1:0] CMD_REQUEST = 2'd1;
	localparam logic [1:0] CMD_FAILED  = 2'd2;
	localparam logic [1:0] CMD_CLEANUP = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_WINDOW     = 3'd0;
	localparam logic [2:0] REG_MAX_REQ    = 3'd1;
	localparam logic [2:0] REG_MAX_FAILED = 3'd2;
	localparam logic [2:0] REG_LOCKOUT    = 3'd3;
	localparam logic [2:0] REG_INTERVAL   = 3'd4;

	// cell operations
	localparam logic [2:0] OP_NOP    = 3'd0;
	localparam logic [2:0] OP_ALLOC  = 3'd1;
	localparam logic [2:0] OP_PRUNE  = 3'd2;
	localparam logic [2:0] OP_APPEND = 3'd3;
	localparam logic [2:0] OP_FAIL   = 3'd4;
	localparam logic [2:0] OP_CLEAN  = 3'd5;

	// control broadcast from the sequencer to every cell
	typedef struct packed {
		logic [2:0]  op;
		logic        first;
		logic [31:0] ip;
		logic [31:0] now;
		logic [31:0] window;
		logic [31:0] lockout;
		logic [7:0]  max_failed;
		logic [31:0] interval;
	} cell_ctl_t;

	// status returned by each cell
	typedef struct packed {
		logic match;
		logic free;
		logic blocked;
		logic evict;
	} cell_stat_t;

endpackage

[hdl/rl_if.sv]
// ----------------------------------------------------------------------------
// rl_req_if / rl_rsp_if
// Valid/ready channels carrying command words and result words.
// ----------------------------------------------------------------------------
interface rl_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] client_ip;
	logic [31:0] now_ms;
	logic        trusted;

	modport source (output valid, cmd, client_ip, now_ms, trusted, input ready);
	modport sink   (input valid, cmd, client_ip, now_ms, trusted, output ready);
endinterface

interface rl_rsp_if;
	logic       valid;
	logic       ready;
	logic       rate_limited;
	logic       blocked;
	logic       tracked;
	logic       dropped_new;
	logic [4:0] removed_count;

	modport source (output valid, rate_limited, blocked, tracked, dropped_new, removed_count,
		input ready);
	modport sink   (input valid, rate_limited, blocked, tracked, dropped_new, removed_count,
		output ready);
endinterface

[hdl/per_client_rate_limiter_core.sv]
// ----------------------------------------------------------------------------
// per_client_rate_limiter_core
// Client table as a row of entry cells driven by a command sequencer.
// Each accepted command is looked up; a pruning check or a request then walks
// the stamp line, a request appends its stamp, a failed login or due cleanup
// takes its own step, and the result word is registered last. Throughput: one
// command at a time, taken only when idle; the prune walks one stamp per cycle.
// Reset: all entries invalid, last cleanup time zero, registers at defaults.
// ----------------------------------------------------------------------------
module per_client_rate_limiter_core #(
	parameter int MAX_CLIENTS = 16,
	parameter int STAMP_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	rl_req_if.sink      req,
	rl_rsp_if.source    rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_data
);
	import rl_pkg::*;

	localparam int CW = $clog2(STAMP_SLOTS + 1);
	localparam int IW = $clog2(STAMP_SLOTS);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOOK   = 3'd1;
	localparam logic [2:0] ST_PRUNE  = 3'd2;
	localparam logic [2:0] ST_APPEND = 3'd3;
	localparam logic [2:0] ST_FAIL   = 3'd4;
	localparam logic [2:0] ST_CLEAN  = 3'd5;
	localparam logic [2:0] ST_RESULT = 3'd6;

	// configuration
	logic [31:0] window_q, lockout_q, interval_q, last_clean_q;
	logic [7:0]  max_req_q, max_failed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= 32'd60000;
			max_req_q    <= 8'd100;
			max_failed_q <= 8'd5;
			lockout_q    <= 32'd300000;
			interval_q   <= 32'd300000;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_WINDOW:     window_q     <= cfg_data;
				REG_MAX_REQ:    max_req_q    <= cfg_data[7:0];
				REG_MAX_FAILED: max_failed_q <= cfg_data[7:0];
				REG_LOCKOUT:    lockout_q    <= cfg_data;
				REG_INTERVAL:   interval_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// command registers
	logic [2:0]             state_q;
	logic [1:0]             cmd_q;
	logic [31:0]            ip_q, now_q;
	logic                   trusted_q;
	logic [MAX_CLIENTS-1:0] sel_q;
	logic [IW-1:0]          step_q;
	logic                   chk_q, limited_q, dropped_q;
	logic [4:0]             removed_q;
	logic                   out_valid_q;

	// cell row
	cell_ctl_t              ctl;
	cell_stat_t             stat [MAX_CLIENTS];
	logic [CW-1:0]          cnt [MAX_CLIENTS];
	logic [MAX_CLIENTS-1:0] en;
	logic [MAX_CLIENTS-1:0] hit_vec, free_oh, blk_vec, evict_vec;
	logic                   any_hit, any_free, sel_blk, due;
	logic [CW-1:0]          sel_cnt;
	logic [8:0]             evict_sum;
	logic [4:0]             evict_sat;

	for (genvar g = 0; g < MAX_CLIENTS; g++) begin : g_cell
		rl_client_cell #(.SLOTS(STAMP_SLOTS)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en[g]),
			.ctl    (ctl),
			.stat   (stat[g]),
			.count  (cnt[g])
		);
	end

	// lookup, lowest free entry, selected-cell readback, eviction count
	always_comb begin
		logic taken;
		taken     = 1'b0;
		sel_cnt   = '0;
		evict_sum = '0;
		for (int i = 0; i < MAX_CLIENTS; i++) begin
			hit_vec[i]   = stat[i].match;
			blk_vec[i]   = stat[i].blocked;
			evict_vec[i] = stat[i].evict;
			free_oh[i]   = stat[i].free && !taken;
			taken        = taken || stat[i].free;
			if (sel_q[i]) begin
				sel_cnt = sel_cnt | cnt[i];
			end
			evict_sum = evict_sum + 9'(evict_vec[i]);
		end
		any_hit   = |hit_vec;
		any_free  = taken;
		sel_blk   = |(hit_vec & blk_vec);
		evict_sat = (evict_sum > 9'd31) ? 5'd31 : evict_sum[4:0];
		due       = (now_q - last_clean_q) >= interval_q;
	end

	// cell control
	always_comb begin
		ctl.first      = (step_q == '0);
		ctl.ip         = ip_q;
		ctl.now        = now_q;
		ctl.window     = window_q;
		ctl.lockout    = lockout_q;
		ctl.max_failed = max_failed_q;
		ctl.interval   = interval_q;
		ctl.op         = OP_NOP;
		en             = sel_q;
		case (state_q)
			ST_LOOK: begin
				en = free_oh;
				if (!any_hit && (cmd_q == CMD_REQUEST ||
					(cmd_q == CMD_FAILED && !trusted_q))) begin
					ctl.op = OP_ALLOC;
				end
			end
			ST_PRUNE:  ctl.op = OP_PRUNE;
			ST_APPEND: ctl.op = OP_APPEND;
			ST_FAIL:   ctl.op = OP_FAIL;
			ST_CLEAN: begin
				ctl.op = OP_CLEAN;
				en     = '1;
			end
			default: begin
			end
		endcase
	end

	assign req.ready = (state_q == ST_IDLE) && !out_valid_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			last_clean_q <= 32'd0;
			step_q       <= '0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid && req.ready) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					step_q  <= '0;
					state_q <= ST_RESULT;
					case (cmd_q)
						CMD_CHECK: begin
							if (!trusted_q && any_hit && !sel_blk) begin
								state_q <= ST_PRUNE;
							end
						end
						CMD_REQUEST: begin
							if (any_hit || any_free) begin
								state_q <= ST_PRUNE;
							end
						end
						CMD_FAILED: begin
							if (!trusted_q && (any_hit || any_free)) begin
								state_q <= ST_FAIL;
							end
						end
						default: begin
							if (due) begin
								state_q      <= ST_CLEAN;
								last_clean_q <= now_q;
							end
						end
					endcase
				end
				ST_PRUNE: begin
					step_q <= step_q + IW'(1);
					if (step_q == IW'(STAMP_SLOTS - 1)) begin
						state_q <= (cmd_q == CMD_REQUEST) ? ST_APPEND : ST_RESULT;
					end
				end
				ST_APPEND, ST_FAIL, ST_CLEAN: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command payload and result flags
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q     <= req.cmd;
				ip_q      <= req.client_ip;
				now_q     <= req.now_ms;
				trusted_q <= req.trusted;
				chk_q     <= 1'b0;
				limited_q <= 1'b0;
				dropped_q <= 1'b0;
				removed_q <= 5'd0;
			end
			ST_LOOK: begin
				sel_q <= any_hit ? hit_vec : free_oh;
				if (cmd_q == CMD_CHECK && !trusted_q && any_hit) begin
					limited_q <= sel_blk;
					chk_q     <= !sel_blk;
				end
				if (!any_hit && !any_free && (cmd_q == CMD_REQUEST ||
					(cmd_q == CMD_FAILED && !trusted_q))) begin
					dropped_q <= 1'b1;
				end
			end
			ST_CLEAN: removed_q <= evict_sat;
			default: begin
			end
		endcase
	end

	// output word
	logic out_limited_q, out_blocked_q, out_tracked_q, out_dropped_q;
	logic [4:0] out_removed_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT) begin
			out_limited_q <= limited_q ||
				(chk_q && (9'(sel_cnt) >= {1'b0, max_req_q}));
			out_blocked_q <= !trusted_q && sel_blk;
			out_tracked_q <= any_hit;
			out_dropped_q <= dropped_q;
			out_removed_q <= removed_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.rate_limited  = out_limited_q;
	assign rsp.blocked       = out_blocked_q;
	assign rsp.tracked       = out_tracked_q;
	assign rsp.dropped_new   = out_dropped_q;
	assign rsp.removed_count = out_removed_q;

endmodule

[hdl/rl_client_cell.sv]
// ----------------------------------------------------------------------------
// rl_client_cell
// One table entry: address, lockout state, last-seen time and a shift line
// of request stamps, oldest at slot 0.
// ----------------------------------------------------------------------------
module rl_client_cell #(
	parameter int SLOTS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  rl_pkg::cell_ctl_t          ctl,
	output rl_pkg::cell_stat_t         stat,
	output logic [$clog2(SLOTS+1)-1:0] count
);
	import rl_pkg::*;

	localparam int CW   = $clog2(SLOTS + 1);
	localparam int IW   = $clog2(SLOTS);
	localparam int HALF = SLOTS / 2;
	localparam int KEEP = SLOTS - HALF;

	logic          valid_q;
	logic [31:0]   addr_q;
	logic [7:0]    failed_q;
	logic [31:0]   deadline_q;
	logic [31:0]   seen_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] kept_q;
	logic [31:0]   slot_q [SLOTS];

	logic [CW-1:0] kept_eff;
	logic          pending;
	logic          keep_head;
	logic [CW-1:0] cnt_dec;
	logic [IW-1:0] last_idx;
	logic [IW-1:0] tail_idx;
	logic [7:0]    fail_inc;

	// prune bookkeeping: stamps ahead of the kept ones are still unvisited
	always_comb begin
		kept_eff  = ctl.first ? '0 : kept_q;
		pending   = cnt_q > kept_eff;
		keep_head = (ctl.now - slot_q[0]) <= ctl.window;
		cnt_dec   = cnt_q - CW'(1);
		last_idx  = cnt_dec[IW-1:0];
		tail_idx  = cnt_q[IW-1:0];
		fail_inc  = failed_q + 8'd1;
	end

	// status
	assign stat.match   = valid_q && (addr_q == ctl.ip);
	assign stat.free    = !valid_q;
	assign stat.blocked = deadline_q > ctl.now;
	assign stat.evict   = valid_q && ((ctl.now - seen_q) > ctl.interval);
	assign count        = cnt_q;

	// entry valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en && ctl.op == OP_ALLOC) begin
			valid_q <= 1'b1;
		end else if (en && ctl.op == OP_CLEAN && stat.evict) begin
			valid_q <= 1'b0;
		end
	end

	// entry payload and stamp line
	always_ff @(posedge clk) begin
		if (en) begin
			case (ctl.op)
				OP_ALLOC: begin
					addr_q     <= ctl.ip;
					failed_q   <= 8'd0;
					deadline_q <= 32'd0;
					cnt_q      <= '0;
				end
				OP_PRUNE: begin
					if (pending) begin
						// rotate: a kept head moves to the tail of the live stamps
						for (int i = 0; i < SLOTS - 1; i++) begin
							slot_q[i] <= (keep_head && i == int'(last_idx)) ?
								slot_q[0] : slot_q[i+1];
						end
						if (keep_head && last_idx == IW'(SLOTS - 1)) begin
							slot_q[SLOTS-1] <= slot_q[0];
						end
						if (keep_head) begin
							kept_q <= kept_eff + CW'(1);
						end else begin
							cnt_q  <= cnt_dec;
							kept_q <= kept_eff;
						end
					end else begin
						kept_q <= kept_eff;
					end
				end
				OP_APPEND: begin
					seen_q <= ctl.now;
					if (cnt_q == CW'(SLOTS)) begin
						for (int i = 0; i < KEEP; i++) begin
							slot_q[i] <= slot_q[i+HALF];
						end
						slot_q[KEEP] <= ctl.now;
						cnt_q <= CW'(KEEP + 1);
					end else begin
						slot_q[tail_idx] <= ctl.now;
						cnt_q <= cnt_q + CW'(1);
					end
				end
				OP_FAIL: begin
					seen_q <= ctl.now;
					if (fail_inc >= ctl.max_failed) begin
						deadline_q <= ctl.now + ctl.lockout;
						failed_q   <= 8'd0;
					end else begin
						failed_q <= fail_inc;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[hdl/rl_checker.sv]
// ----------------------------------------------------------------------------
// rl_checker
// Port-level checks of the rate limiter, bound to the top level.
// ----------------------------------------------------------------------------
module rl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       rate_limited,
	input logic       tracked,
	input logic       dropped_new,
	input logic [4:0] removed_count
);

	// a waiting result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(removed_count))
		else $error("result word dropped or changed while stalled");

	// no new command is taken while a result waits
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("command accepted while result pending");

	// the result never appears in the cycle after acceptance
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("result too early");

	// limited or blocked client must be tracked; a dropped one is not
	a_limited_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rate_limited |-> tracked && !dropped_new)
		else $error("limited client not tracked");

	a_dropped_untracked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped_new |-> !tracked && removed_count == 5'd0)
		else $error("dropped client shows as tracked");

endmodule

bind per_client_rate_limiter_core rl_checker u_rl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (req.valid),
	.in_ready      (req.ready),
	.out_valid     (rsp.valid),
	.out_ready     (rsp.ready),
	.rate_limited  (rsp.rate_limited),
	.tracked       (rsp.tracked),
	.dropped_new   (rsp.dropped_new),
	.removed_count (rsp.removed_count)
);

[verif/per_client_rate_limiter_core_tb.sv]
// ----------------------------------------------------------------------------
// per_client_rate_limiter_core_tb
// Drives command words into the rate limiter core with random gaps on both
// channels, predicts each result word from a model of the client table and
// compares every field of every result word.
// ----------------------------------------------------------------------------
module per_client_rate_limiter_core_tb;
	import rl_pkg::*;

	localparam int NCLI  = 16;
	localparam int NSTMP = 16;
	localparam int LIMIT = 2000000;

	// index past the register list, must be ignored
	localparam logic [2:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic       rate_limited;
		logic       blocked;
		logic       tracked;
		logic       dropped_new;
		logic [4:0] removed_count;
	} verdict_t;

	// table model and pending verdicts
	class limiter_board;
		bit [31:0] window, lockout, interval, last_clean;
		bit [7:0]  max_req, max_fail;
		bit        live[NCLI];
		bit [31:0] addr[NCLI], deadline[NCLI], seen[NCLI];
		bit [7:0]  fails[NCLI];
		bit [31:0] stamps[NCLI][NSTMP];
		int        nstamp[NCLI];
		verdict_t  pending[$];
		int        errors;

		function void clear();
			window = 32'd60000; max_req = 8'd100; max_fail = 8'd5;
			lockout = 32'd300000; interval = 32'd300000; last_clean = 32'd0;
			foreach (live[i]) live[i] = 1'b0;
			pending.delete();
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] d);
			case (idx)
				REG_WINDOW:     window = d;
				REG_MAX_REQ:    max_req = d[7:0];
				REG_MAX_FAILED: max_fail = d[7:0];
				REG_LOCKOUT:    lockout = d;
				REG_INTERVAL:   interval = d;
				default: ;
			endcase
		endfunction

		function int lookup(bit [31:0] ip);
			for (int i = 0; i < NCLI; i++)
				if (live[i] && addr[i] == ip) return i;
			return -1;
		endfunction

		function int claim(bit [31:0] ip);
			for (int i = 0; i < NCLI; i++)
				if (!live[i]) begin
					live[i] = 1'b1; addr[i] = ip; fails[i] = 8'd0;
					deadline[i] = 32'd0; nstamp[i] = 0;
					return i;
				end
			return -1;
		endfunction

		function void trim(int s, bit [31:0] now);
			int w;
			bit [31:0] age;
			w = 0;
			for (int r = 0; r < nstamp[s]; r++) begin
				age = now - stamps[s][r];
				if (age <= window) begin
					stamps[s][w] = stamps[s][r];
					w++;
				end
			end
			nstamp[s] = w;
		endfunction

		// note an accepted command word
		function void note_word(logic [1:0] cmd, bit [31:0] ip, bit [31:0] now, bit tr);
			verdict_t v;
			int s;
			bit [31:0] dt;
			v = '0;
			s = lookup(ip);
			case (cmd)
				CMD_CHECK: begin
					if (!tr && s >= 0) begin
						if (deadline[s] > now) v.rate_limited = 1'b1;
						else begin
							trim(s, now);
							v.rate_limited = nstamp[s] >= max_req;
						end
					end
				end
				CMD_REQUEST: begin
					if (s < 0) begin
						s = claim(ip);
						if (s < 0) v.dropped_new = 1'b1;
					end
					if (s >= 0) begin
						trim(s, now);
						if (nstamp[s] >= NSTMP) begin
							for (int k = 0; k < NSTMP / 2; k++)
								stamps[s][k] = stamps[s][k + NSTMP / 2];
							nstamp[s] = NSTMP / 2;
						end
						stamps[s][nstamp[s]] = now;
						nstamp[s]++;
						seen[s] = now;
					end
				end
				CMD_FAILED: begin
					if (!tr) begin
						if (s < 0) begin
							s = claim(ip);
							if (s < 0) v.dropped_new = 1'b1;
						end
						if (s >= 0) begin
							fails[s] = fails[s] + 8'd1;
							seen[s] = now;
							if (fails[s] >= max_fail) begin
								deadline[s] = now + lockout;
								fails[s] = 8'd0;
							end
						end
					end
				end
				default: begin
					dt = now - last_clean;
					if (dt >= interval) begin
						last_clean = now;
						for (int i = 0; i < NCLI; i++) begin
							dt = now - seen[i];
							if (live[i] && dt > interval) begin
								live[i] = 1'b0;
								v.removed_count++;
							end
						end
					end
					s = lookup(ip);
				end
			endcase
			v.tracked = s >= 0;
			v.blocked = s >= 0 && !tr && deadline[s] > now;
			pending = {pending, v};
		endfunction

		// compare a result word with the oldest verdict
		function void check_word(verdict_t got);
			verdict_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.rate_limited != exp.rate_limited)
				$display("%0t: rate_limited exp %0d got %0d", $time,
					exp.rate_limited, got.rate_limited);
			if (got.blocked != exp.blocked)
				$display("%0t: blocked exp %0d got %0d", $time, exp.blocked, got.blocked);
			if (got.tracked != exp.tracked)
				$display("%0t: tracked exp %0d got %0d", $time, exp.tracked, got.tracked);
			if (got.dropped_new != exp.dropped_new)
				$display("%0t: dropped_new exp %0d got %0d", $time,
					exp.dropped_new, got.dropped_new);
			if (got.removed_count != exp.removed_count)
				$display("%0t: removed_count exp %0d got %0d", $time,
					exp.removed_count, got.removed_count);
			if (got !== exp) errors++;
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_idx = '0;
	logic [31:0] cfg_data = '0;
	int          cycles = 0;
	bit [31:0]   clock_ms = 32'd0;
	bit [31:0]   ip_pool[8];
	limiter_board board;

	rl_req_if req();
	rl_rsp_if rsp();

	per_client_rate_limiter_core DUT (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	initial begin
		req.valid = 1'b0; req.cmd = CMD_CHECK; req.client_ip = '0;
		req.now_ms = '0; req.trusted = 1'b0;
		rsp.ready = 1'b0;
	end

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// result side: random stalls, check on each handshake
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			board.check_word({rsp.rate_limited, rsp.blocked, rsp.tracked,
				rsp.dropped_new, rsp.removed_count});
		if (arst_n) rsp.ready <= ($urandom_range(0, 99) < 70);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_word(logic [1:0] cmd, logic [31:0] ip, logic [31:0] now, logic tr);
		req.valid     <= 1'b1;
		req.cmd       <= cmd;
		req.client_ip <= ip;
		req.now_ms    <= now;
		req.trusted   <= tr;
		do @(posedge clk); while (!req.ready);
		board.note_word(cmd, ip, now, tr);
		if ($urandom_range(0, 3) == 0) begin
			int g;
			g = gap_len();
			if (g > 0) begin
				req.valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] d);
		cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_reg(idx, d);
	endtask

	// pick a time advancing mostly in small steps, sometimes jumping far
	function bit [31:0] next_ms();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) clock_ms += $urandom_range(0, 20);
		else if (r < 95) clock_ms += $urandom_range(0, 200);
		else clock_ms += $urandom;
		return clock_ms;
	endfunction

	task automatic random_phase(int n);
		logic [1:0] cmd;
		bit [31:0] ip, now;
		for (int k = 0; k < n; k++) begin
			cmd = 2'($urandom_range(0, 3));
			if ($urandom_range(0, 99) < 25) cmd = CMD_CLEANUP;
			if ($urandom_range(0, 9) == 0) ip = $urandom;
			else ip = ip_pool[$urandom_range(0, 7)] + $urandom_range(0, 19);
			now = ($urandom_range(0, 49) == 0) ? $urandom : next_ms();
			send_word(cmd, ip, now, $urandom_range(0, 5) == 0);
		end
	endtask

	initial begin
		board = new();
		board.clear();
		board.errors = 0;
		foreach (ip_pool[i]) ip_pool[i] = $urandom;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every command, lockout, full stamp line, eviction
		write_reg(REG_MAX_FAILED, 32'd2);
		write_reg(REG_WINDOW, 32'd50);
		write_reg(REG_MAX_REQ, 32'd3);
		write_reg(REG_LOCKOUT, 32'd100);
		write_reg(REG_INTERVAL, 32'd1000);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		send_word(CMD_CHECK, 32'h0, 32'h0, 1'b0);
		for (int k = 0; k < 18; k++)
			send_word(CMD_REQUEST, 32'hFFFF_FFFF, 32'(k), 1'b0);
		send_word(CMD_CHECK, 32'hFFFF_FFFF, 32'd20, 1'b0);
		send_word(CMD_CHECK, 32'hFFFF_FFFF, 32'd20, 1'b1);
		send_word(CMD_FAILED, 32'h1, 32'd30, 1'b0);
		send_word(CMD_FAILED, 32'h1, 32'd31, 1'b0);
		send_word(CMD_CHECK, 32'h1, 32'd40, 1'b0);
		send_word(CMD_FAILED, 32'h1, 32'hFFFF_FFFF, 1'b1);
		send_word(CMD_CLEANUP, 32'h1, 32'hFFFF_FFFF, 1'b0);
		drain();

		// fill the table, then try a new client
		for (int k = 0; k < 17; k++)
			send_word(CMD_REQUEST, 32'h100 + 32'(k), 32'd5000, 1'b0);
		send_word(CMD_FAILED, 32'h200, 32'd5001, 1'b0);
		send_word(CMD_CLEANUP, 32'h0, 32'd9000, 1'b0);
		drain();
		clock_ms = 32'd9000;

		// settings: zero, tight, moderate, wide, then moderate again
		write_reg(REG_MAX_REQ, 32'd0);
		write_reg(REG_MAX_FAILED, 32'd0);
		random_phase(150);
		drain();
		write_reg(REG_WINDOW, 32'd1);
		write_reg(REG_MAX_REQ, 32'd1);
		write_reg(REG_MAX_FAILED, 32'd1);
		write_reg(REG_LOCKOUT, 32'd1);
		write_reg(REG_INTERVAL, 32'd1);
		random_phase(300);
		drain();
		write_reg(REG_WINDOW, 32'd300);
		write_reg(REG_MAX_REQ, 32'd6);
		write_reg(REG_MAX_FAILED, 32'd3);
		write_reg(REG_LOCKOUT, 32'd500);
		write_reg(REG_INTERVAL, 32'd800);
		random_phase(600);
		drain();
		write_reg(REG_WINDOW, 32'hFFFF_FFFF);
		write_reg(REG_MAX_REQ, 32'd255);
		write_reg(REG_MAX_FAILED, 32'd255);
		write_reg(REG_LOCKOUT, 32'hFFFF_FFFF);
		write_reg(REG_INTERVAL, 32'hFFFF_FFFF);
		random_phase(300);
		drain();
		write_reg(REG_WINDOW, 32'd2000);
		write_reg(REG_MAX_REQ, 32'd12);
		write_reg(REG_MAX_FAILED, 32'd4);
		write_reg(REG_LOCKOUT, 32'd3000);
		write_reg(REG_INTERVAL, 32'd400);
		random_phase(380);
		drain();

		if (board.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

[per_client_rate_limiter_core.f]
hdl/rl_pkg.sv
hdl/rl_if.sv
hdl/rl_client_cell.sv
hdl/per_client_rate_limiter_core.sv
hdl/rl_checker.sv
verif/per_client_rate_limiter_core_tb.sv
